// ----- src/zip_load_current_injection_assert.svh -----
// assertion macros for the zip load current injection block
// no dependencies; taken in by the files that assert
`ifndef ZIP_LOAD_CURRENT_INJECTION_ASSERT_SVH
`define ZIP_LOAD_CURRENT_INJECTION_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ZLCI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("zlci: same-cycle check failed");

// condition holds in the cycle after the trigger
`define ZLCI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("zlci: next-cycle check failed");

`endif

// ----- src/zlci_pkg.sv -----
// shared constants and types for the zip load current injection block
// no dependencies
package zlci_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int WORD_BITS  = 32;
  localparam int MAG_BITS   = 64;
  localparam int DIV_BITS   = MAG_BITS + FRAC_BITS;
  localparam int QUO_BITS   = WORD_BITS + 1;
  localparam int CMP_BITS   = MAG_BITS + QUO_BITS;
  localparam int SQRT_STEPS = MAG_BITS / 2;
  localparam int RND_BITS   = MAG_BITS - FRAC_BITS;
  localparam int SAT_BITS   = RND_BITS + 1;

  // bus model codes
  localparam logic [1:0] FUNC_POWER     = 2'd0;
  localparam logic [1:0] FUNC_IMPEDANCE = 2'd1;
  localparam logic [1:0] FUNC_CURRENT   = 2'd2;
  localparam logic [1:0] FUNC_SLACK     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_COND = 2'd0;
  localparam logic [1:0] REG_SUSC = 2'd1;
  localparam logic [1:0] REG_VMIN = 2'd2;

  // front end result: conj(S)*V, or (g+jb)*u_ref for slack, as sign and magnitude, and |V|^2
  typedef struct packed {
    logic [1:0]          func;
    logic                pzero;
    logic                floor_hit;
    logic                neg_r;
    logic                neg_i;
    logic [MAG_BITS-1:0] mag_r;
    logic [MAG_BITS-1:0] mag_i;
    logic [MAG_BITS-1:0] m;
  } bus_t;

endpackage

// ----- src/zip_load_current_injection.sv -----
// ZIP load current injection: use of the block
// Input channel in_*: one bus item per accepted cycle (in_valid high, in_stall
// low) carrying the model code, P, Q, the bus voltage and the slack reference.
// Result channel out_*: one current item per bus item, in order, with
// out_clipped set when a part saturated, the divisor was zero or the voltage floor applied.
// Config port cfg_*: cfg_we with cfg_index writes conductance, susceptance or
// the voltage floor; write only while the block is idle.
// Path of an item: the accepting edge loads the first of two front stages, then a
// 32-cell square root chain, a setup stage, a 33-cell divider chain and the
// output register follow.
// Throughput: one item per cycle while in_stall is low; every cell of both chains
// finishes one step each such cycle and hands on to its neighbour.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps taking items until its last stage holds one; then in_stall
// rises and the whole pipeline holds until the result is taken.
// depends on zlci_pkg, zlci_front, zlci_sqrt_cell, zlci_div_cell
`include "zip_load_current_injection_assert.svh"

module zip_load_current_injection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_p_spec,
  input  logic signed [31:0]  in_q_spec,
  input  logic signed [31:0]  in_volt_real,
  input  logic signed [31:0]  in_volt_imag,
  input  logic signed [31:0]  in_ref_magnitude,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_amp_real,
  output logic signed [31:0]  out_amp_imag,
  output logic                out_clipped,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import zlci_pkg::*;

  localparam int NSTG = 2 + SQRT_STEPS + 1 + QUO_BITS;

  typedef struct packed {
    logic [1:0]          func;
    logic                pzero;
    logic                floor_hit;
    logic                neg_r;
    logic                neg_i;
    logic [RND_BITS-1:0] dir_r;
    logic [RND_BITS-1:0] dir_i;
    logic                ovf_r;
    logic                ovf_i;
    logic                dzero;
    logic [MAG_BITS-1:0] dvsr;
  } tail_t;

  function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                  input logic [SAT_BITS-1:0] mag,
                                                  input logic ovf);
    logic [SAT_BITS-1:0]  lim;
    logic [WORD_BITS-1:0] neg_mag;
    lim     = SAT_BITS'(1) << (WORD_BITS - 1);
    neg_mag = -mag[WORD_BITS-1:0];
    if (neg) begin
      if (ovf || mag > lim) return {1'b1, lim[WORD_BITS-1:0]};
      return {1'b0, neg_mag};
    end
    if (ovf || mag > lim - SAT_BITS'(1)) return {1'b1, lim[WORD_BITS-1:0] - WORD_BITS'(1)};
    return {1'b0, mag[WORD_BITS-1:0]};
  endfunction

  logic signed [31:0] cond_r, susc_r;
  logic [30:0]        vmin_r;
  logic [NSTG-1:0]    vld_r;
  logic               adv;

  bus_t                front_bus;
  bus_t                side_r [SQRT_STEPS];
  logic [MAG_BITS-1:0] sq_rem [SQRT_STEPS];
  logic [MAG_BITS-1:0] sq_res [SQRT_STEPS];

  bus_t                su_bus;
  logic                su_pow;
  logic [MAG_BITS-1:0] su_dvsr;
  logic [DIV_BITS-1:0] su_dvd_r, su_dvd_i;
  logic [MAG_BITS-1:0] half;
  tail_t               su_nxt, su_r;
  logic [DIV_BITS-1:0] dvd_r_r, dvd_i_r;

  tail_t               tside_r [QUO_BITS];
  logic [DIV_BITS-1:0] dv_rem_r [QUO_BITS];
  logic [DIV_BITS-1:0] dv_rem_i [QUO_BITS];
  logic [QUO_BITS-1:0] dv_quo_r [QUO_BITS];
  logic [QUO_BITS-1:0] dv_quo_i [QUO_BITS];

  tail_t               tl;
  logic                rnd_r, rnd_i;
  logic [SAT_BITS-1:0] qmag_r, qmag_i;
  logic [WORD_BITS:0]  sat_r, sat_i;
  logic [WORD_BITS-1:0] res_r_nxt, res_i_nxt;
  logic                clip_nxt;

  logic                out_valid_r;
  logic signed [31:0]  out_real_r, out_imag_r;
  logic                out_clip_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_r <= 32'sd16777216;
      susc_r <= -32'sd167772160;
      vmin_r <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COND: cond_r <= $signed(cfg_data);
        REG_SUSC: susc_r <= $signed(cfg_data);
        REG_VMIN: vmin_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless its last stage is blocked by a held result
  assign adv      = !(vld_r[NSTG-1] && out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // front end
  zlci_front u_front (
    .clk            (clk),
    .adv            (adv),
    .func           (in_func),
    .p_spec         (in_p_spec),
    .q_spec         (in_q_spec),
    .volt_real      (in_volt_real),
    .volt_imag      (in_volt_imag),
    .ref_magnitude  (in_ref_magnitude),
    .cond           (cond_r),
    .susc           (susc_r),
    .vmin           (vmin_r),
    .bus_o          (front_bus)
  );

  // square root chain of |V|^2 with the item riding alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= front_bus;
      for (int k = 1; k < SQRT_STEPS; k++) side_r[k] <= side_r[k-1];
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [MAG_BITS-1:0] rem_in, res_in;
    if (k == 0) begin : g_first
      assign rem_in = front_bus.m;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = sq_rem[k-1];
      assign res_in = sq_res[k-1];
    end
    zlci_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .adv   (adv),
      .rem_i (rem_in),
      .res_i (res_in),
      .rem_o (sq_rem[k]),
      .res_o (sq_res[k])
    );
  end

  // divider setup: divisor, dividends, overflow and direct rounding
  always_comb begin
    su_bus   = side_r[SQRT_STEPS-1];
    su_pow   = su_bus.func == FUNC_POWER;
    su_dvsr  = su_pow ? su_bus.m : sq_res[SQRT_STEPS-1];
    su_dvd_r = su_pow ? {su_bus.mag_r, {FRAC_BITS{1'b0}}} : DIV_BITS'(su_bus.mag_r);
    su_dvd_i = su_pow ? {su_bus.mag_i, {FRAC_BITS{1'b0}}} : DIV_BITS'(su_bus.mag_i);
    half     = MAG_BITS'(1) << (FRAC_BITS - 1);
    su_nxt.func      = su_bus.func;
    su_nxt.pzero     = su_bus.pzero;
    su_nxt.floor_hit = su_bus.floor_hit;
    su_nxt.neg_r     = su_bus.neg_r;
    su_nxt.neg_i     = su_bus.neg_i;
    su_nxt.dir_r     = RND_BITS'((su_bus.mag_r + half) >> FRAC_BITS);
    su_nxt.dir_i     = RND_BITS'((su_bus.mag_i + half) >> FRAC_BITS);
    su_nxt.ovf_r     = CMP_BITS'(su_dvd_r) >= (CMP_BITS'(su_dvsr) << QUO_BITS);
    su_nxt.ovf_i     = CMP_BITS'(su_dvd_i) >= (CMP_BITS'(su_dvsr) << QUO_BITS);
    su_nxt.dzero     = su_dvsr == '0;
    su_nxt.dvsr      = su_dvsr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      su_r    <= su_nxt;
      dvd_r_r <= su_dvd_r;
      dvd_i_r <= su_dvd_i;
    end
  end

  // divider chain, one lane per current part
  always_ff @(posedge clk) begin
    if (adv) begin
      tside_r[0] <= su_r;
      for (int j = 1; j < QUO_BITS; j++) tside_r[j] <= tside_r[j-1];
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    logic [DIV_BITS-1:0] rem_r_in, rem_i_in;
    logic [QUO_BITS-1:0] quo_r_in, quo_i_in;
    logic [MAG_BITS-1:0] dvsr_in;
    if (j == 0) begin : g_first
      assign rem_r_in = dvd_r_r;
      assign rem_i_in = dvd_i_r;
      assign quo_r_in = '0;
      assign quo_i_in = '0;
      assign dvsr_in  = su_r.dvsr;
    end else begin : g_next
      assign rem_r_in = dv_rem_r[j-1];
      assign rem_i_in = dv_rem_i[j-1];
      assign quo_r_in = dv_quo_r[j-1];
      assign quo_i_in = dv_quo_i[j-1];
      assign dvsr_in  = tside_r[j-1].dvsr;
    end
    zlci_div_cell #(.SHIFT(QUO_BITS - 1 - j)) u_re (
      .clk    (clk),
      .adv    (adv),
      .rem_i  (rem_r_in),
      .dvsr_i (dvsr_in),
      .quo_i  (quo_r_in),
      .rem_o  (dv_rem_r[j]),
      .quo_o  (dv_quo_r[j])
    );
    zlci_div_cell #(.SHIFT(QUO_BITS - 1 - j)) u_im (
      .clk    (clk),
      .adv    (adv),
      .rem_i  (rem_i_in),
      .dvsr_i (dvsr_in),
      .quo_i  (quo_i_in),
      .rem_o  (dv_rem_i[j]),
      .quo_o  (dv_quo_i[j])
    );
  end

  // final rounding, model selection and saturation
  always_comb begin
    tl     = tside_r[QUO_BITS-1];
    rnd_r  = {dv_rem_r[QUO_BITS-1][MAG_BITS-1:0], 1'b0} >= {1'b0, tl.dvsr};
    rnd_i  = {dv_rem_i[QUO_BITS-1][MAG_BITS-1:0], 1'b0} >= {1'b0, tl.dvsr};
    qmag_r = SAT_BITS'(dv_quo_r[QUO_BITS-1]) + SAT_BITS'(rnd_r);
    qmag_i = SAT_BITS'(dv_quo_i[QUO_BITS-1]) + SAT_BITS'(rnd_i);
    if (tl.func == FUNC_SLACK || (tl.func == FUNC_IMPEDANCE && !tl.pzero)) begin
      sat_r = sat_word(tl.neg_r, SAT_BITS'(tl.dir_r), 1'b0);
      sat_i = sat_word(tl.neg_i, SAT_BITS'(tl.dir_i), 1'b0);
    end else if (tl.pzero) begin
      sat_r = '0;
      sat_i = '0;
    end else if (tl.dzero) begin
      sat_r = {1'b1, {WORD_BITS{1'b0}}};
      sat_i = {1'b1, {WORD_BITS{1'b0}}};
    end else begin
      sat_r = sat_word(tl.neg_r, qmag_r, tl.ovf_r);
      sat_i = sat_word(tl.neg_i, qmag_i, tl.ovf_i);
    end
    res_r_nxt = sat_r[WORD_BITS-1:0];
    res_i_nxt = sat_i[WORD_BITS-1:0];
    clip_nxt  = tl.floor_hit || sat_r[WORD_BITS] || sat_i[WORD_BITS];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (vld_r[NSTG-1] && adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[NSTG-1] && adv) begin
      out_real_r <= $signed(res_r_nxt);
      out_imag_r <= $signed(res_i_nxt);
      out_clip_r <= clip_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_amp_real = out_real_r;
  assign out_amp_imag = out_imag_r;
  assign out_clipped  = out_clip_r;

  // checks
  `ZLCI_ASSERT_NEXT(a_result_loaded, clk, rst_n, vld_r[NSTG-1] && adv, out_valid_r)
  `ZLCI_ASSERT_IMPL(a_sqrt_fits, clk, rst_n, vld_r[SQRT_STEPS+1], sq_res[SQRT_STEPS-1][MAG_BITS-1:MAG_BITS/2] == '0)
  `ZLCI_ASSERT_IMPL(a_rem_below_dvsr, clk, rst_n, vld_r[NSTG-1] && !tl.ovf_r, dv_rem_r[QUO_BITS-1] < DIV_BITS'(tl.dvsr))

endmodule

// ----- src/zlci_sqrt_cell.sv -----
// one step of the integer square root chain, one result bit per cell
// depends on zlci_pkg
module zlci_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [zlci_pkg::MAG_BITS-1:0] rem_i,
  input  logic [zlci_pkg::MAG_BITS-1:0] res_i,
  output logic [zlci_pkg::MAG_BITS-1:0] rem_o,
  output logic [zlci_pkg::MAG_BITS-1:0] res_o
);
  import zlci_pkg::*;

  localparam logic [MAG_BITS-1:0] BIT = MAG_BITS'(1) << (MAG_BITS - 2 - 2 * STEP);

  logic [MAG_BITS:0]   trial;
  logic                ge;
  logic [MAG_BITS-1:0] rem_nxt, res_nxt;
  logic [MAG_BITS-1:0] rem_r, res_r;

  // trial subtract of res + bit
  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    ge    = {1'b0, rem_i} >= trial;
    if (ge) begin
      rem_nxt = rem_i - trial[MAG_BITS-1:0];
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign rem_o = rem_r;
  assign res_o = res_r;

endmodule

// ----- src/zlci_div_cell.sv -----
// one restoring division step, one quotient bit per cell
// depends on zlci_pkg
module zlci_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [zlci_pkg::DIV_BITS-1:0] rem_i,
  input  logic [zlci_pkg::MAG_BITS-1:0] dvsr_i,
  input  logic [zlci_pkg::QUO_BITS-1:0] quo_i,
  output logic [zlci_pkg::DIV_BITS-1:0] rem_o,
  output logic [zlci_pkg::QUO_BITS-1:0] quo_o
);
  import zlci_pkg::*;

  logic [CMP_BITS-1:0] sub;
  logic                ge;
  logic [DIV_BITS-1:0] rem_nxt;
  logic [QUO_BITS-1:0] quo_nxt;
  logic [DIV_BITS-1:0] rem_r;
  logic [QUO_BITS-1:0] quo_r;

  // compare against the divisor at this bit weight
  always_comb begin
    sub     = CMP_BITS'(dvsr_i) << SHIFT;
    ge      = CMP_BITS'(rem_i) >= sub;
    rem_nxt = ge ? DIV_BITS'(CMP_BITS'(rem_i) - sub) : rem_i;
    quo_nxt = {quo_i[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// ----- src/zlci_front.sv -----
// front end: products, voltage floor and conj(S)*V, two registered stages
// depends on zlci_pkg
module zlci_front (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [1:0]           func,
  input  logic signed [31:0]   p_spec,
  input  logic signed [31:0]   q_spec,
  input  logic signed [31:0]   volt_real,
  input  logic signed [31:0]   volt_imag,
  input  logic signed [31:0]   ref_magnitude,
  input  logic signed [31:0]   cond,
  input  logic signed [31:0]   susc,
  input  logic [30:0]          vmin,
  output zlci_pkg::bus_t       bus_o
);
  import zlci_pkg::*;

  function automatic logic [MAG_BITS:0] sign_mag(input logic signed [MAG_BITS+1:0] s);
    logic signed [MAG_BITS+1:0] a;
    a = s[MAG_BITS+1] ? -s : s;
    return {s[MAG_BITS+1], a[MAG_BITS-1:0]};
  endfunction

  logic               slack;
  logic signed [31:0] op_a1, op_a2, op_b, vm_s;

  logic [1:0]         func1_r;
  logic               pzero1_r;
  logic signed [63:0] pa_r, pb_r, qvi_r, pvi_r, vrr_r, vii_r, pvm_r, qvm_r;
  logic [61:0]        vmm_r;

  logic [MAG_BITS-1:0]        m_raw, m_sel;
  logic                       low, floor_hit;
  logic signed [MAG_BITS+1:0] s_r, s_i;
  logic [MAG_BITS:0]          sm_r, sm_i;
  bus_t                       bus_nxt, bus_r;

  // operand selection: slack reuses two multipliers for (g+jb)*u_ref
  always_comb begin
    slack = func == FUNC_SLACK;
    op_a1 = slack ? cond : p_spec;
    op_a2 = slack ? susc : q_spec;
    op_b  = slack ? ref_magnitude : volt_real;
    vm_s  = $signed({1'b0, vmin});
  end

  // stage one: all products
  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r  <= func;
      pzero1_r <= (p_spec == 32'sd0) && (q_spec == 32'sd0);
      pa_r     <= op_a1 * op_b;
      pb_r     <= op_a2 * op_b;
      qvi_r    <= q_spec * volt_imag;
      pvi_r    <= p_spec * volt_imag;
      vrr_r    <= volt_real * volt_real;
      vii_r    <= volt_imag * volt_imag;
      pvm_r    <= p_spec * vm_s;
      qvm_r    <= q_spec * vm_s;
      vmm_r    <= vmin * vmin;
    end
  end

  // stage two: |V|^2, floor and sums as sign and magnitude
  always_comb begin
    m_raw = $unsigned(vrr_r) + $unsigned(vii_r);
    low   = m_raw < {2'b00, vmm_r};
    m_sel = m_raw;
    if (func1_r == FUNC_SLACK) begin
      s_r = 66'(pa_r);
      s_i = 66'(pb_r);
    end else if (low) begin
      s_r   = 66'(pvm_r);
      s_i   = -66'(qvm_r);
      m_sel = {2'b00, vmm_r};
    end else begin
      s_r = 66'(pa_r) + 66'(qvi_r);
      s_i = 66'(pvi_r) - 66'(pb_r);
    end
    floor_hit = (func1_r != FUNC_SLACK) && !pzero1_r && low;
    sm_r = sign_mag(s_r);
    sm_i = sign_mag(s_i);
    bus_nxt.func      = func1_r;
    bus_nxt.pzero     = pzero1_r;
    bus_nxt.floor_hit = floor_hit;
    bus_nxt.neg_r     = sm_r[MAG_BITS];
    bus_nxt.neg_i     = sm_i[MAG_BITS];
    bus_nxt.mag_r     = sm_r[MAG_BITS-1:0];
    bus_nxt.mag_i     = sm_i[MAG_BITS-1:0];
    bus_nxt.m         = m_sel;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule
